// ===== rtl/elrc_pkg.sv =====
// elrc_pkg: shared constants, register indexes, error codes and types of the
// extent list region checker. Used by every module under rtl.
// No dependencies.
package elrc_pkg;

  localparam int ADDR_BITS_DEF  = 41;
  localparam int COUNT_BITS_DEF = 16;
  localparam int QUEUE_DEPTH    = 4;

  localparam int OFS_W   = 40;
  localparam int LEN_W   = 40;
  localparam int FEND_W  = 41;
  localparam int IMG_W   = 36;
  localparam int SECT_W  = 16;
  localparam int FRAG_W  = 16;
  localparam int LIM_W   = 41;
  localparam int ERR_W   = 4;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 41;
  localparam int IN_TDATA_W = OFS_W + LEN_W;

  localparam logic [SECT_W-1:0] SECTOR_MIN = SECT_W'(512);
  localparam logic [SECT_W-1:0] SECTOR_MAX = SECT_W'(4096);

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_BYTES = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SECTOR_SIZE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_USED_FRAGS  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FLOOR       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DUAL_THRESH = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_LIMIT       = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_FRAG_CAP    = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_FRAG_RSV    = 3'd7;

  localparam logic [IMG_W-1:0]  RST_IMAGE_BYTES = '0;
  localparam logic [SECT_W-1:0] RST_SECTOR_SIZE = SECT_W'(512);
  localparam logic [FRAG_W-1:0] RST_USED_FRAGS  = '0;
  localparam logic [IMG_W-1:0]  RST_FLOOR       = '0;
  localparam logic [IMG_W-1:0]  RST_DUAL_THRESH = IMG_W'(64'd4699979776);
  localparam logic [LIM_W-1:0]  RST_LIMIT       = LIM_W'(64'd2147483648);
  localparam logic [FRAG_W-1:0] RST_FRAG_CAP    = FRAG_W'(1024);
  localparam logic [FRAG_W-1:0] RST_FRAG_RSV    = '0;

  localparam logic [ERR_W-1:0] ERR_NONE       = 4'd0;
  localparam logic [ERR_W-1:0] ERR_NOT_POW2   = 4'd1;
  localparam logic [ERR_W-1:0] ERR_SIZE_RANGE = 4'd2;
  localparam logic [ERR_W-1:0] ERR_EMPTY      = 4'd3;
  localparam logic [ERR_W-1:0] ERR_DUAL_LAYER = 4'd4;
  localparam logic [ERR_W-1:0] ERR_BELOW      = 4'd5;
  localparam logic [ERR_W-1:0] ERR_MISALIGN   = 4'd6;
  localparam logic [ERR_W-1:0] ERR_ORDER      = 4'd7;
  localparam logic [ERR_W-1:0] ERR_OVERFLOW   = 4'd8;
  localparam logic [ERR_W-1:0] ERR_OVER_LIMIT = 4'd9;
  localparam logic [ERR_W-1:0] ERR_FRAGS      = 4'd10;

  typedef struct packed {
    logic [SECT_W-1:0] align_mask;
    logic [SECT_W-1:0] round_mask;
    logic              bad_pow2;
    logic              bad_range;
    logic              dual_layer;
    logic [LIM_W-1:0]  limit;
    logic [FRAG_W-1:0] frags_free;
  } cfg_view_t;

  typedef struct packed {
    logic below;
    logic misal;
    logic over;
  } ext_flags_t;

  localparam int FLAGS_W = $bits(ext_flags_t);

endpackage

// ===== rtl/elrc_cfg.sv =====
// elrc_cfg: configuration register file and the values derived from it
// (region start, sector masks and checks, free fragment count).
// Depends on elrc_pkg.
module elrc_cfg
  import elrc_pkg::*;
#(
  parameter int ADDR_BITS = ADDR_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output logic [ADDR_BITS-1:0]  region_start,
  output cfg_view_t             view
);

  logic [IMG_W-1:0]  image_r, floor_r, dual_r;
  logic [SECT_W-1:0] sector_r;
  logic [FRAG_W-1:0] used_r, cap_r, rsv_r;
  logic [LIM_W-1:0]  limit_r;

  logic [IMG_W-1:0]    base;
  logic [IMG_W:0]      base_sum;
  logic [IMG_W:0]      base_rnd;
  logic [FRAG_W:0]     taken;
  logic [SECT_W-1:0]   round_mask;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_r  <= RST_IMAGE_BYTES;
      sector_r <= RST_SECTOR_SIZE;
      used_r   <= RST_USED_FRAGS;
      floor_r  <= RST_FLOOR;
      dual_r   <= RST_DUAL_THRESH;
      limit_r  <= RST_LIMIT;
      cap_r    <= RST_FRAG_CAP;
      rsv_r    <= RST_FRAG_RSV;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_IMAGE_BYTES: image_r  <= cfg_data[IMG_W-1:0];
        REG_SECTOR_SIZE: sector_r <= cfg_data[SECT_W-1:0];
        REG_USED_FRAGS:  used_r   <= cfg_data[FRAG_W-1:0];
        REG_FLOOR:       floor_r  <= cfg_data[IMG_W-1:0];
        REG_DUAL_THRESH: dual_r   <= cfg_data[IMG_W-1:0];
        REG_LIMIT:       limit_r  <= cfg_data[LIM_W-1:0];
        REG_FRAG_CAP:    cap_r    <= cfg_data[FRAG_W-1:0];
        REG_FRAG_RSV:    rsv_r    <= cfg_data[FRAG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    round_mask = (sector_r == '0) ? '0 : sector_r - SECT_W'(1);
    base       = (image_r > floor_r) ? image_r : floor_r;
    base_sum   = (IMG_W+1)'(base) + (IMG_W+1)'(round_mask);
    base_rnd   = base_sum & ~((IMG_W+1)'(round_mask));
    taken      = (FRAG_W+1)'(rsv_r) + (FRAG_W+1)'(used_r);

    region_start    = ADDR_BITS'(base_rnd);
    view.align_mask = sector_r - SECT_W'(1);
    view.round_mask = round_mask;
    view.bad_pow2   = (sector_r == '0) || ((sector_r & (sector_r - SECT_W'(1))) != '0);
    view.bad_range  = (sector_r < SECTOR_MIN) || (sector_r > SECTOR_MAX);
    view.dual_layer = (image_r >= dual_r);
    view.limit      = limit_r;
    view.frags_free = (taken >= (FRAG_W+1)'(cap_r)) ? '0
                                                    : FRAG_W'((FRAG_W+1)'(cap_r) - taken);
  end

endmodule

// ===== rtl/elrc_front.sv =====
// elrc_front: classifies each input beat against the region start, sector
// alignment and limit, and packs it into a queue entry.
// Depends on elrc_pkg.
module elrc_front
  import elrc_pkg::*;
#(
  parameter int ADDR_BITS = ADDR_BITS_DEF,
  localparam int ENT_W    = 1 + FLAGS_W + ADDR_BITS + LEN_W + OFS_W
) (
  input  logic                  in_last,
  input  logic [OFS_W-1:0]      in_offset,
  input  logic [LEN_W-1:0]      in_length,
  input  logic [ADDR_BITS-1:0]  region_start,
  input  cfg_view_t             view,
  output logic [ENT_W-1:0]      entry
);

  localparam int XW = (ADDR_BITS > FEND_W) ? ADDR_BITS : FEND_W;

  logic [FEND_W-1:0] fend;
  ext_flags_t        flags;

  always_comb begin
    fend        = FEND_W'(in_offset) + FEND_W'(in_length);
    flags.below = XW'(in_offset) < XW'(region_start);
    flags.misal = (in_offset[SECT_W-1:0] & view.align_mask) != '0;
    flags.over  = (XW'(fend) > XW'({ADDR_BITS{1'b1}})) || (fend > view.limit);
    entry       = {in_last, flags, ADDR_BITS'(fend), in_length, in_offset};
  end

endmodule

// ===== rtl/elrc_queue.sv =====
// elrc_queue: short register fifo between the front and back parts.
// Depends on elrc_pkg for the default depth.
module elrc_queue
  import elrc_pkg::*;
#(
  parameter int WIDTH = 8,
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_valid,
  output logic             wr_ready,
  input  logic [WIDTH-1:0] wr_data,
  output logic             rd_valid,
  input  logic             rd_ready,
  output logic [WIDTH-1:0] rd_data
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wptr_r, rptr_r;
  logic [CW-1:0]    count_r;
  logic             do_wr, do_rd;

  assign wr_ready = (count_r != CW'(DEPTH));
  assign rd_valid = (count_r != '0);
  assign rd_data  = mem_r[rptr_r];
  assign do_wr    = wr_valid && wr_ready;
  assign do_rd    = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      if (do_wr) begin
        wptr_r <= (wptr_r == PW'(DEPTH - 1)) ? '0 : wptr_r + PW'(1);
      end
      if (do_rd) begin
        rptr_r <= (rptr_r == PW'(DEPTH - 1)) ? '0 : rptr_r + PW'(1);
      end
      if (do_wr && !do_rd) begin
        count_r <= count_r + CW'(1);
      end else if (do_rd && !do_wr) begin
        count_r <= count_r - CW'(1);
      end
    end
  end

endmodule

// ===== rtl/elrc_back.sv =====
// elrc_back: list state (ends, sum, count, first error), verdict stage and
// output register. Depends on elrc_pkg.
module elrc_back
  import elrc_pkg::*;
#(
  parameter int ADDR_BITS  = ADDR_BITS_DEF,
  parameter int COUNT_BITS = COUNT_BITS_DEF,
  localparam int ENT_W     = 1 + FLAGS_W + ADDR_BITS + LEN_W + OFS_W
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  q_valid,
  output logic                  q_ready,
  input  logic [ENT_W-1:0]      q_data,
  input  logic [ADDR_BITS-1:0]  region_start,
  input  cfg_view_t             view,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  ok,
  output logic [ERR_W-1:0]      error_code,
  output logic [ADDR_BITS-1:0]  region_start_out,
  output logic [ADDR_BITS-1:0]  region_end_out,
  output logic [ADDR_BITS-1:0]  payload_total_out,
  output logic [COUNT_BITS-1:0] files_out,
  output logic [FRAG_W-1:0]     frags_free,
  output logic [ADDR_BITS-1:0]  headroom
);

  localparam int XW  = (ADDR_BITS > FEND_W) ? ADDR_BITS : FEND_W;
  localparam int EW  = XW + 1;
  localparam int FCW = (COUNT_BITS > FRAG_W) ? COUNT_BITS : FRAG_W;

  logic                 e_last;
  ext_flags_t           e_flags;
  logic [ADDR_BITS-1:0] e_fend;
  logic [LEN_W-1:0]     e_len;
  logic [OFS_W-1:0]     e_off;

  logic [ADDR_BITS-1:0]  prev_end_r, high_end_r, sum_r;
  logic [COUNT_BITS-1:0] count_r;
  logic [ERR_W-1:0]      fault_r;

  logic                  v_valid_r;
  logic [ERR_W-1:0]      v_code_r;
  logic [ADDR_BITS-1:0]  v_start_r, v_sum_r;
  logic [EW-1:0]         v_end_r;
  logic [COUNT_BITS-1:0] v_count_r;

  logic                  out_valid_r, ok_r;
  logic [ERR_W-1:0]      err_r;
  logic [ADDR_BITS-1:0]  start_r, end_r, total_r, head_r;
  logic [COUNT_BITS-1:0] files_r;
  logic [FRAG_W-1:0]     free_r;

  logic                  out_free, v_free, pop;
  logic [ERR_W-1:0]      fault_nxt, pre_code, v_code;
  logic [EW-1:0]         sum_ext, end_nxt;
  logic [ADDR_BITS-1:0]  sum_nxt, end_base;
  logic                  ext_good;

  assign {e_last, e_flags, e_fend, e_len, e_off} = q_data;

  assign out_free = !out_valid_r || out_ready;
  assign v_free   = !v_valid_r || out_free;
  assign q_ready  = !e_last || v_free;
  assign pop      = q_valid && q_ready;

  always_comb begin
    fault_nxt = fault_r;
    ext_good  = 1'b0;
    if (fault_r == ERR_NONE) begin
      if (e_flags.below) begin
        fault_nxt = ERR_BELOW;
      end else if (e_flags.misal) begin
        fault_nxt = ERR_MISALIGN;
      end else if ((count_r != '0) && (XW'(e_off) < XW'(prev_end_r))) begin
        fault_nxt = ERR_ORDER;
      end else if (e_flags.over) begin
        fault_nxt = ERR_OVERFLOW;
      end else begin
        ext_good = 1'b1;
      end
    end
    sum_ext = EW'(sum_r) + EW'(e_len);
    sum_nxt = (sum_ext > EW'({ADDR_BITS{1'b1}})) ? {ADDR_BITS{1'b1}} : ADDR_BITS'(sum_ext);

    end_base = (high_end_r > region_start) ? high_end_r : region_start;
    end_nxt  = (EW'(end_base) + EW'(view.round_mask)) & ~(EW'(view.round_mask));

    if (view.bad_pow2) begin
      pre_code = ERR_NOT_POW2;
    end else if (view.bad_range) begin
      pre_code = ERR_SIZE_RANGE;
    end else if (count_r == '0) begin
      pre_code = ERR_EMPTY;
    end else if (view.dual_layer) begin
      pre_code = ERR_DUAL_LAYER;
    end else begin
      pre_code = fault_r;
    end

    if (v_code_r != ERR_NONE) begin
      v_code = v_code_r;
    end else if (v_end_r > EW'(view.limit)) begin
      v_code = ERR_OVER_LIMIT;
    end else if (FCW'(v_count_r) > FCW'(view.frags_free)) begin
      v_code = ERR_FRAGS;
    end else begin
      v_code = ERR_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_end_r <= '0;
      high_end_r <= '0;
      sum_r      <= '0;
      count_r    <= '0;
      fault_r    <= ERR_NONE;
    end else if (pop) begin
      if (e_last) begin
        prev_end_r <= region_start;
        high_end_r <= region_start;
        sum_r      <= '0;
        count_r    <= '0;
        fault_r    <= ERR_NONE;
      end else begin
        fault_r <= fault_nxt;
        if (ext_good) begin
          prev_end_r <= e_fend;
          sum_r      <= sum_nxt;
          if (e_fend > high_end_r) begin
            high_end_r <= e_fend;
          end
        end
        if (count_r != {COUNT_BITS{1'b1}}) begin
          count_r <= count_r + COUNT_BITS'(1);
        end
      end
    end
  end

  // verdict stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_valid_r <= 1'b0;
    end else if (v_free) begin
      v_valid_r <= pop && e_last;
    end
  end

  always_ff @(posedge clk) begin
    if (v_free && pop && e_last) begin
      v_code_r  <= pre_code;
      v_start_r <= region_start;
      v_end_r   <= end_nxt;
      v_sum_r   <= sum_r;
      v_count_r <= count_r;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= v_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && v_valid_r) begin
      ok_r  <= (v_code == ERR_NONE);
      err_r <= v_code;
      if (v_code == ERR_NONE) begin
        start_r <= v_start_r;
        end_r   <= ADDR_BITS'(v_end_r);
        total_r <= v_sum_r;
        files_r <= v_count_r;
        free_r  <= view.frags_free;
        head_r  <= ADDR_BITS'(EW'(view.limit) - v_end_r);
      end else begin
        start_r <= '0;
        end_r   <= '0;
        total_r <= '0;
        files_r <= '0;
        free_r  <= '0;
        head_r  <= '0;
      end
    end
  end

  assign out_valid         = out_valid_r;
  assign ok                = ok_r;
  assign error_code        = err_r;
  assign region_start_out  = start_r;
  assign region_end_out    = end_r;
  assign payload_total_out = total_r;
  assign files_out         = files_r;
  assign frags_free        = free_r;
  assign headroom          = head_r;

endmodule

// ===== rtl/extent_list_region_checker.sv =====
// extent_list_region_checker: top level, wires config, front, queue and back.
// Depends on elrc_pkg, elrc_cfg, elrc_front, elrc_queue, elrc_back.
//
// Usage: stream one extent per in_ beat (in_tlast low), then one beat with
// in_tlast high to close the list. Extent beats give no result; the closing
// beat gives one verdict beat on out_. Registers are written through the cfg_
// channel (always ready); the user must write them only while no list item
// is in flight, the block does not check it. Throughput: one input beat per
// cycle while out_ keeps up, set by the list state update in the back part.
// A verdict goes from the queue head through the verdict stage and output reg.
// Reset: registers return to their defaults, the list state is cleared and
// the queue is emptied; there is no clearing pass.
// Receiver stall: the output register and verdict stage hold; extents keep
// draining until a closing beat reaches the queue head, then the four-entry
// queue fills and in_tready drops.
module extent_list_region_checker
  import elrc_pkg::*;
#(
  parameter int ADDR_BITS  = ADDR_BITS_DEF,
  parameter int COUNT_BITS = COUNT_BITS_DEF,
  localparam int OUT_W  = 1 + ERR_W + 4 * ADDR_BITS + COUNT_BITS + FRAG_W,
  localparam int OUT_TW = ((OUT_W + 7) / 8) * 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_TDATA_W-1:0] in_tdata,   // offset, length
  input  logic                  in_tlast,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // ok, error_code, region_start_out, region_end_out, payload_total_out,
  // files_out, frags_free, headroom
  output logic [OUT_TW-1:0]     out_tdata,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int ENT_W = 1 + FLAGS_W + ADDR_BITS + LEN_W + OFS_W;

  logic [ADDR_BITS-1:0]  region_start;
  cfg_view_t             view;
  logic [ENT_W-1:0]      wr_entry, rd_entry;
  logic                  q_valid, q_ready;

  logic                  ok;
  logic [ERR_W-1:0]      error_code;
  logic [ADDR_BITS-1:0]  region_start_out, region_end_out, payload_total_out, headroom;
  logic [COUNT_BITS-1:0] files_out;
  logic [FRAG_W-1:0]     frags_free;

  elrc_cfg #(.ADDR_BITS(ADDR_BITS)) u_cfg (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .region_start (region_start),
    .view         (view)
  );

  elrc_front #(.ADDR_BITS(ADDR_BITS)) u_front (
    .in_last      (in_tlast),
    .in_offset    (in_tdata[OFS_W-1:0]),
    .in_length    (in_tdata[OFS_W+LEN_W-1:OFS_W]),
    .region_start (region_start),
    .view         (view),
    .entry        (wr_entry)
  );

  elrc_queue #(.WIDTH(ENT_W), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (in_tvalid),
    .wr_ready (in_tready),
    .wr_data  (wr_entry),
    .rd_valid (q_valid),
    .rd_ready (q_ready),
    .rd_data  (rd_entry)
  );

  elrc_back #(.ADDR_BITS(ADDR_BITS), .COUNT_BITS(COUNT_BITS)) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_valid           (q_valid),
    .q_ready           (q_ready),
    .q_data            (rd_entry),
    .region_start      (region_start),
    .view              (view),
    .out_valid         (out_tvalid),
    .out_ready         (out_tready),
    .ok                (ok),
    .error_code        (error_code),
    .region_start_out  (region_start_out),
    .region_end_out    (region_end_out),
    .payload_total_out (payload_total_out),
    .files_out         (files_out),
    .frags_free        (frags_free),
    .headroom          (headroom)
  );

  assign out_tdata = OUT_TW'({headroom, frags_free, files_out, payload_total_out,
                              region_end_out, region_start_out, error_code, ok});

endmodule

// ===== tb/sv/tb_extent_list_region_checker.sv =====
// tb_extent_list_region_checker: self-checking bench for the extent list region checker.
// Streams extent lists and register settings, predicts each verdict and compares it
// field by field. Depends on elrc_pkg and the extent_list_region_checker RTL.
module tb_extent_list_region_checker;
  import elrc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int AW          = ADDR_BITS_DEF;
  localparam int CW          = COUNT_BITS_DEF;
  localparam int OUT_W       = 1 + ERR_W + 4 * AW + CW + FRAG_W;
  localparam int OUT_TW      = ((OUT_W + 7) / 8) * 8;
  localparam int SETTLE_PAD  = 8;
  localparam int CYCLE_LIMIT = 2000000;
  localparam int PHASES      = 12;
  localparam int PHASE_BEATS = 100;

  localparam int PHASE_EXTREME_HIGH = 0;
  localparam int PHASE_EXTREME_LOW  = 1;
  localparam int PHASE_NO_IDLE      = 4;
  localparam int PHASE_PRESSURE     = 6;

  localparam logic [63:0] MAX36 = 64'hF_FFFF_FFFF;
  localparam logic [63:0] MAX40 = 64'hFF_FFFF_FFFF;
  localparam logic [63:0] MAX41 = 64'h1FF_FFFF_FFFF;

  typedef struct packed {
    logic              ok;
    logic [ERR_W-1:0]  code;
    logic [AW-1:0]     rstart;
    logic [AW-1:0]     rend;
    logic [AW-1:0]     payload;
    logic [CW-1:0]     files;
    logic [FRAG_W-1:0] frags;
    logic [AW-1:0]     headroom;
  } verdict_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_TDATA_W-1:0] in_tdata = '0;
  logic                  in_tlast = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_TW-1:0]     out_tdata;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  extent_list_region_checker u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // register copies
  logic [IMG_W-1:0]  img_r;
  logic [SECT_W-1:0] sect_r;
  logic [FRAG_W-1:0] used_r;
  logic [IMG_W-1:0]  floor_r;
  logic [IMG_W-1:0]  dual_r;
  logic [LIM_W-1:0]  limit_r;
  logic [FRAG_W-1:0] cap_r;
  logic [FRAG_W-1:0] rsv_r;

  // list state
  logic [AW-1:0]    prev_end;
  logic [AW-1:0]    high_end;
  logic [AW-1:0]    payload_sum;
  logic [CW-1:0]    file_count;
  logic [ERR_W-1:0] first_fault;

  verdict_t verdict_q[$];

  int src_idle_pct  = 35;
  int sink_idle_pct = 35;
  int mismatches    = 0;
  int verdicts_seen = 0;
  int lists_closed  = 0;
  int extents_sent  = 0;
  int beats_sent    = 0;
  int cfg_writes    = 0;
  int cycles        = 0;

  always #5 clk = ~clk;

  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= sink_idle_pct);
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d verdicts pending", cycles, verdict_q.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  task automatic report(input string what);
    mismatches++;
    if (mismatches <= 50) $display("[%0t] %s", $time, what);
  endtask

  function automatic logic [63:0] rand_bits(input int n);
    logic [63:0] r;
    r = {$urandom(), $urandom()};
    return (n <= 0) ? 64'd0 : r >> (64 - n);
  endfunction

  function automatic logic [63:0] round_to_sector(input logic [63:0] v);
    logic [63:0] m;
    m = (sect_r == '0) ? 64'd0 : 64'(sect_r) - 64'd1;
    return (v + m) & ~m;
  endfunction

  function automatic logic [AW-1:0] region_start();
    logic [63:0] s;
    s = (img_r > floor_r) ? 64'(img_r) : 64'(floor_r);
    return AW'(round_to_sector(s));
  endfunction

  task automatic clear_list_state();
    logic [AW-1:0] s;
    s = region_start();
    prev_end    = s;
    high_end    = s;
    payload_sum = '0;
    file_count  = '0;
    first_fault = ERR_NONE;
  endtask

  task automatic load_defaults();
    img_r   = RST_IMAGE_BYTES;
    sect_r  = RST_SECTOR_SIZE;
    used_r  = RST_USED_FRAGS;
    floor_r = RST_FLOOR;
    dual_r  = RST_DUAL_THRESH;
    limit_r = RST_LIMIT;
    cap_r   = RST_FRAG_CAP;
    rsv_r   = RST_FRAG_RSV;
    clear_list_state();
  endtask

  task automatic absorb_extent(input logic [OFS_W-1:0] off, input logic [LEN_W-1:0] len);
    logic [AW-1:0]     start;
    logic [AW-1:0]     fend;
    logic [SECT_W-1:0] amask;
    logic [AW:0]       sum;
    start = region_start();
    fend  = {1'b0, off} + {1'b0, len};
    amask = sect_r - SECT_W'(1);
    if (first_fault == ERR_NONE) begin
      if ({1'b0, off} < start) begin
        first_fault = ERR_BELOW;
      end else if ((off[SECT_W-1:0] & amask) != '0) begin
        first_fault = ERR_MISALIGN;
      end else if (file_count != '0 && {1'b0, off} < prev_end) begin
        first_fault = ERR_ORDER;
      end else if (fend > limit_r) begin
        first_fault = ERR_OVERFLOW;
      end else begin
        prev_end = fend;
        if (fend > high_end) high_end = fend;
        sum = {1'b0, payload_sum} + (AW + 1)'(len);
        payload_sum = sum[AW] ? '1 : sum[AW-1:0];
      end
    end
    if (file_count != '1) file_count++;
    extents_sent++;
  endtask

  task automatic judge_list();
    verdict_t          v;
    logic [AW-1:0]     start;
    logic [63:0]       rend;
    logic [FRAG_W:0]   taken;
    logic [FRAG_W-1:0] freef;
    logic [ERR_W-1:0]  code;
    start = region_start();
    code  = ERR_NONE;
    rend  = '0;
    freef = '0;
    v     = '0;
    if (sect_r == '0 || (sect_r & (sect_r - SECT_W'(1))) != '0) begin
      code = ERR_NOT_POW2;
    end else if (sect_r < SECTOR_MIN || sect_r > SECTOR_MAX) begin
      code = ERR_SIZE_RANGE;
    end else if (file_count == '0) begin
      code = ERR_EMPTY;
    end else if (img_r >= dual_r) begin
      code = ERR_DUAL_LAYER;
    end else if (first_fault != ERR_NONE) begin
      code = first_fault;
    end else begin
      rend = round_to_sector(64'((high_end > start) ? high_end : start));
      if (rend > 64'(limit_r)) begin
        code = ERR_OVER_LIMIT;
      end else begin
        taken = {1'b0, rsv_r} + {1'b0, used_r};
        freef = (taken >= {1'b0, cap_r}) ? '0 : FRAG_W'({1'b0, cap_r} - taken);
        if (64'(file_count) > 64'(freef)) code = ERR_FRAGS;
      end
    end
    v.code = code;
    v.ok   = (code == ERR_NONE);
    if (v.ok) begin
      v.rstart   = start;
      v.rend     = rend[AW-1:0];
      v.payload  = payload_sum;
      v.files    = file_count;
      v.frags    = freef;
      v.headroom = limit_r - rend[AW-1:0];
    end
    verdict_q.push_back(v);
    lists_closed++;
    clear_list_state();
  endtask

  task automatic check_field(input string name, input logic [63:0] got,
                             input logic [63:0] want);
    if (got !== want) begin
      report($sformatf("verdict %0d: %s got %0h want %0h", verdicts_seen, name, got, want));
    end
  endtask

  always @(posedge clk) begin
    verdict_t got;
    verdict_t want;
    if (rst_n && out_tvalid && out_tready) begin
      verdicts_seen++;
      got.ok       = out_tdata[0];
      got.code     = out_tdata[1 +: ERR_W];
      got.rstart   = out_tdata[1 + ERR_W +: AW];
      got.rend     = out_tdata[1 + ERR_W + AW +: AW];
      got.payload  = out_tdata[1 + ERR_W + 2 * AW +: AW];
      got.files    = out_tdata[1 + ERR_W + 3 * AW +: CW];
      got.frags    = out_tdata[1 + ERR_W + 3 * AW + CW +: FRAG_W];
      got.headroom = out_tdata[1 + ERR_W + 3 * AW + CW + FRAG_W +: AW];
      if (verdict_q.size() == 0) begin
        report($sformatf("verdict %0d arrived with no list closed", verdicts_seen));
      end else begin
        want = verdict_q.pop_front();
        check_field("ok", 64'(got.ok), 64'(want.ok));
        check_field("error_code", 64'(got.code), 64'(want.code));
        check_field("region_start", 64'(got.rstart), 64'(want.rstart));
        check_field("region_end", 64'(got.rend), 64'(want.rend));
        check_field("payload_total", 64'(got.payload), 64'(want.payload));
        check_field("files", 64'(got.files), 64'(want.files));
        check_field("frags_free", 64'(got.frags), 64'(want.frags));
        check_field("headroom", 64'(got.headroom), 64'(want.headroom));
      end
    end
  end

  task automatic drive_beat(input logic last, input logic [OFS_W-1:0] off,
                            input logic [LEN_W-1:0] len);
    while ($urandom_range(99) < src_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tlast  <= last;
    in_tdata  <= {len, off};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    beats_sent++;
    if (last) judge_list();
    else absorb_extent(off, len);
  endtask

  task automatic put_extent(input logic [63:0] off, input logic [63:0] len);
    drive_beat(1'b0, off[OFS_W-1:0], len[LEN_W-1:0]);
  endtask

  task automatic close_list();
    drive_beat(1'b1, '0, '0);
  endtask

  // hold the stream until every verdict is back and the pipe has emptied
  task automatic settle_idle();
    in_tvalid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (SETTLE_PAD) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val[CFG_DATA_W-1:0];
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_IMAGE_BYTES: img_r   = val[IMG_W-1:0];
      REG_SECTOR_SIZE: sect_r  = val[SECT_W-1:0];
      REG_USED_FRAGS:  used_r  = val[FRAG_W-1:0];
      REG_FLOOR:       floor_r = val[IMG_W-1:0];
      REG_DUAL_THRESH: dual_r  = val[IMG_W-1:0];
      REG_LIMIT:       limit_r = val[LIM_W-1:0];
      REG_FRAG_CAP:    cap_r   = val[FRAG_W-1:0];
      REG_FRAG_RSV:    rsv_r   = val[FRAG_W-1:0];
      default: ;
    endcase
    cfg_writes++;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic test_defaults();
    close_list();
    put_extent(0, 1000);
    put_extent(1024, 0);
    close_list();
    settle_idle();
  endtask

  task automatic test_sector_rules();
    write_reg(REG_SECTOR_SIZE, 0);
    put_extent(0, 512);
    close_list();
    settle_idle();
    write_reg(REG_SECTOR_SIZE, 768);
    close_list();
    settle_idle();
    write_reg(REG_SECTOR_SIZE, 256);
    put_extent(256, 256);
    close_list();
    settle_idle();
    write_reg(REG_SECTOR_SIZE, 8192);
    close_list();
    settle_idle();
    write_reg(REG_SECTOR_SIZE, 4096);
  endtask

  task automatic test_extent_faults();
    write_reg(REG_FLOOR, 40960);
    write_reg(REG_IMAGE_BYTES, 12345);
    put_extent(4096, 10);
    close_list();
    put_extent(40960 + 512, 0);
    close_list();
    put_extent(40960, 8192);
    put_extent(45056, 0);
    put_extent(0, 0);
    close_list();
    put_extent(40960, MAX40);
    close_list();
    settle_idle();
    write_reg(REG_LIMIT, 40960 + 4096 + 100);
    put_extent(40960 + 4096, 100);
    close_list();
    settle_idle();
  endtask

  task automatic test_verdict_gates();
    write_reg(REG_IMAGE_BYTES, MAX36);
    put_extent(0, 0);
    close_list();
    settle_idle();
    write_reg(REG_IMAGE_BYTES, 0);
    write_reg(REG_FLOOR, 0);
    write_reg(REG_LIMIT, MAX41);
    write_reg(REG_FRAG_CAP, 2);
    put_extent(0, 4096);
    put_extent(8192, 0);
    put_extent(64'hFF_FFFF_F000, 64'hFFF);
    close_list();
    settle_idle();
    write_reg(REG_FRAG_CAP, 65535);
    write_reg(REG_FRAG_RSV, 65535);
    write_reg(REG_USED_FRAGS, 65535);
    put_extent(0, 0);
    close_list();
    settle_idle();
    write_reg(REG_FRAG_RSV, 0);
    write_reg(REG_USED_FRAGS, 0);
    put_extent(64'hFF_FFFF_F000, MAX40);
    close_list();
    settle_idle();
  endtask

  task automatic random_config(input int phase);
    logic [63:0] img;
    logic [63:0] lim;
    logic [63:0] dual;
    if (phase == PHASE_EXTREME_HIGH) begin
      write_reg(REG_SECTOR_SIZE, 4096);
      write_reg(REG_IMAGE_BYTES, 0);
      write_reg(REG_FLOOR, MAX36);
      write_reg(REG_LIMIT, MAX41);
      write_reg(REG_DUAL_THRESH, MAX36);
      write_reg(REG_FRAG_CAP, 65535);
      write_reg(REG_USED_FRAGS, 0);
      write_reg(REG_FRAG_RSV, 0);
    end else if (phase == PHASE_EXTREME_LOW) begin
      write_reg(REG_SECTOR_SIZE, 512);
      write_reg(REG_IMAGE_BYTES, 0);
      write_reg(REG_FLOOR, 0);
      write_reg(REG_LIMIT, 0);
      write_reg(REG_DUAL_THRESH, 1);
      write_reg(REG_FRAG_CAP, 0);
      write_reg(REG_USED_FRAGS, 0);
      write_reg(REG_FRAG_RSV, 0);
    end else begin
      if ($urandom_range(99) < 85) write_reg(REG_SECTOR_SIZE, 512 << $urandom_range(0, 3));
      else write_reg(REG_SECTOR_SIZE, $urandom_range(0, 65535));
      img = rand_bits($urandom_range(0, 36));
      write_reg(REG_IMAGE_BYTES, img);
      write_reg(REG_FLOOR, rand_bits($urandom_range(0, 36)));
      if ($urandom_range(99) < 75) lim = 64'(region_start()) + rand_bits($urandom_range(10, 34));
      else lim = rand_bits($urandom_range(0, 41));
      write_reg(REG_LIMIT, (lim > MAX41) ? MAX41 : lim);
      if ($urandom_range(99) < 85) dual = img + 64'd1 + rand_bits($urandom_range(0, 36));
      else dual = rand_bits($urandom_range(0, 36));
      write_reg(REG_DUAL_THRESH, (dual > MAX36) ? MAX36 : dual);
      if ($urandom_range(99) < 80) write_reg(REG_FRAG_CAP, $urandom_range(16, 65535));
      else write_reg(REG_FRAG_CAP, $urandom_range(0, 15));
      if ($urandom_range(99) < 80) begin
        write_reg(REG_USED_FRAGS, $urandom_range(0, 8));
        write_reg(REG_FRAG_RSV, $urandom_range(0, 8));
      end else begin
        write_reg(REG_USED_FRAGS, $urandom_range(0, 65535));
        write_reg(REG_FRAG_RSV, $urandom_range(0, 65535));
      end
    end
  endtask

  // ascending, aligned extents with random gaps; now and then one is broken
  task automatic send_plan(input int n);
    logic [63:0]      cursor;
    logic [63:0]      off;
    logic [63:0]      len;
    logic [63:0]      last_off;
    logic [63:0]      s;
    logic [ERR_W-1:0] inj;
    int               i;
    s        = 64'(region_start());
    cursor   = s;
    last_off = s;
    for (i = 0; i < n; i++) begin
      off = round_to_sector(cursor);
      if ($urandom_range(99) < 40) off = off + 64'(sect_r) * $urandom_range(1, 4);
      len = rand_bits($urandom_range(0, 20));
      if ($urandom_range(99) < 6) begin
        inj = ERR_BELOW + ERR_W'($urandom_range(0, 3));
        case (inj)
          ERR_BELOW:    if (s != 0) off = rand_bits(64) % s;
          ERR_MISALIGN: off = off + $urandom_range(1, 511);
          ERR_ORDER:    off = last_off;
          default:      len = MAX40 - rand_bits(20);
        endcase
      end
      put_extent(off, len);
      last_off = off & MAX40;
      cursor   = (off & MAX40) + (len & MAX40);
    end
    close_list();
  endtask

  task automatic send_noise(input int n);
    int i;
    for (i = 0; i < n; i++) begin
      put_extent(rand_bits($urandom_range(0, 40)), rand_bits($urandom_range(0, 40)));
    end
    close_list();
  endtask

  task automatic test_random_lists();
    int phase;
    int phase_start;
    int r;
    bit paused;
    for (phase = 0; phase < PHASES; phase++) begin
      settle_idle();
      random_config(phase);
      src_idle_pct  = (phase == PHASE_NO_IDLE) ? 0 : 35;
      sink_idle_pct = (phase == PHASE_NO_IDLE) ? 0 : 35;
      phase_start   = beats_sent;
      paused        = 1'b0;
      while (beats_sent - phase_start < PHASE_BEATS) begin
        r = $urandom_range(99);
        if (r < 70) send_plan($urandom_range(1, 10));
        else if (r < 92) send_noise($urandom_range(1, 8));
        else close_list();
        if (phase == PHASE_PRESSURE && !paused && beats_sent - phase_start > PHASE_BEATS / 2) begin
          settle_idle();
          paused = 1'b1;
        end
      end
    end
    src_idle_pct  = 35;
    sink_idle_pct = 35;
  endtask

  initial begin
    load_defaults();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_defaults();
    test_sector_rules();
    test_extent_faults();
    test_verdict_gates();
    test_random_lists();
    settle_idle();
    $display("ran %0d lists with %0d extents under %0d register writes",
             lists_closed, extents_sent, cfg_writes);
    $display("checked %0d verdicts in %0d cycles", verdicts_seen, cycles);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/elrc_pkg.sv
rtl/elrc_cfg.sv
rtl/elrc_front.sv
rtl/elrc_queue.sv
rtl/elrc_back.sv
rtl/extent_list_region_checker.sv
tb/sv/tb_extent_list_region_checker.sv
